// ----- rtl/ipv4fr_pkg.sv -----
// Shared types and constants for the IPv4 datagram fragmenter.
`default_nettype none

package ipv4fr_pkg;

  localparam logic [2:0] KIND_SEND        = 3'd0;
  localparam logic [2:0] KIND_FRAG        = 3'd1;
  localparam logic [2:0] KIND_FRAG_NEEDED = 3'd2;
  localparam logic [2:0] KIND_TIME_EXCEED = 3'd3;
  localparam logic [2:0] KIND_CANNOT      = 3'd4;

  typedef struct packed {
    logic [15:0] dgram_length;
    logic [5:0]  header_length;
    logic        dont_fragment;
    logic        more_fragments_in;
    logic [7:0]  hop_limit;
    logic [15:0] link_mtu;
    logic [7:0]  iface_id;
    logic [31:0] next_hop;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] frag_length;
    logic [15:0] frag_offset;
    logic        more_flag;
    logic [7:0]  out_iface;
    logic [31:0] out_next_hop;
    logic        last;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_EMIT
  } fsm_state_e;

  typedef struct packed {
    logic load;
    logic calc;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic single;
    logic frag_last;
  } dp_status_t;

endpackage

`default_nettype wire

// ----- rtl/ipv4fr_ctrl.sv -----
// Control state machine: input acceptance, sequencing and output register valid.
`default_nettype none

module ipv4fr_ctrl (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  input  wire ipv4fr_pkg::dp_status_t status_i,
  output ipv4fr_pkg::dp_cmd_t         cmd_o
);
  import ipv4fr_pkg::*;

  fsm_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  assign slot_free = !out_valid_q || !out_stall_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_CALC;
      end
      ST_CALC: state_d = ST_EMIT;
      ST_EMIT: begin
        if (slot_free && (status_i.single || status_i.frag_last)) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      ST_CALC: cmd_o.calc = 1'b1;
      ST_EMIT: cmd_o.emit = slot_free;
      default: cmd_o = '0;
    endcase
    out_valid_d = cmd_o.emit ? 1'b1 : (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ----- rtl/ipv4fr_datapath.sv -----
// Datapath: item registers, fragment step arithmetic and the output register.
`default_nettype none

module ipv4fr_datapath #(
  parameter int MaxFragments = 64
) (
  input  wire logic                 clk_i,
  input  wire ipv4fr_pkg::in_item_t in_item_i,
  input  wire ipv4fr_pkg::dp_cmd_t  cmd_i,
  output ipv4fr_pkg::dp_status_t    status_o,
  output ipv4fr_pkg::out_item_t     out_item_o
);
  import ipv4fr_pkg::*;

  localparam int CntW   = $clog2(MaxFragments + 1);
  localparam int LimitW = 16 + CntW;
  localparam logic [CntW-1:0] MaxFragsC = CntW'(MaxFragments);

  in_item_t          item_q;
  logic [15:0]       step_q;
  logic [15:0]       remaining_q;
  logic [15:0]       offset_q;
  logic [LimitW-1:0] limit_q;
  out_item_t         out_q;

  logic      fits, mtu_bad, too_many, expired;
  logic      single, frag_last;
  out_item_t out_d;

  assign fits      = item_q.dgram_length <= item_q.link_mtu;
  assign mtu_bad   = item_q.link_mtu <= {10'd0, item_q.header_length};
  assign too_many  = {{CntW{1'b0}}, remaining_q} > limit_q;
  assign expired   = item_q.hop_limit == 8'd0;
  assign single    = fits || mtu_bad || item_q.dont_fragment || too_many;
  assign frag_last = remaining_q <= step_q;

  assign status_o.single    = single;
  assign status_o.frag_last = frag_last;

  always_comb begin
    out_d.out_iface    = item_q.iface_id;
    out_d.out_next_hop = item_q.next_hop;
    if (single) begin
      if (fits)                       out_d.kind = expired ? KIND_TIME_EXCEED : KIND_SEND;
      else if (mtu_bad)               out_d.kind = KIND_CANNOT;
      else if (item_q.dont_fragment)  out_d.kind = KIND_FRAG_NEEDED;
      else                            out_d.kind = KIND_CANNOT;
      out_d.frag_length = item_q.dgram_length;
      out_d.frag_offset = 16'd0;
      out_d.more_flag   = item_q.more_fragments_in;
      out_d.last        = 1'b1;
    end else begin
      out_d.kind        = expired ? KIND_TIME_EXCEED : KIND_FRAG;
      out_d.frag_length = frag_last ? (item_q.dgram_length - offset_q) : item_q.link_mtu;
      out_d.frag_offset = offset_q;
      out_d.more_flag   = frag_last ? item_q.more_fragments_in : 1'b1;
      out_d.last        = frag_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) item_q <= in_item_i;
    if (cmd_i.calc) begin
      step_q      <= item_q.link_mtu - {10'd0, item_q.header_length};
      remaining_q <= item_q.dgram_length - {10'd0, item_q.header_length};
      limit_q     <= LimitW'(item_q.link_mtu - {10'd0, item_q.header_length}) * MaxFragsC;
      offset_q    <= 16'd0;
    end
    if (cmd_i.emit) begin
      out_q <= out_d;
      if (!single) begin
        offset_q    <= offset_q + step_q;
        remaining_q <= remaining_q - step_q;
      end
    end
  end

  assign out_item_o = out_q;

endmodule

`default_nettype wire

// ----- rtl/ipv4_datagram_fragmenter_unit.sv -----
// Top level of the IPv4 datagram fragmenter: controller plus datapath.
// Flow: an accepted item is loaded, then its step and fragment limit are computed, then
// its results go to the output register one per cycle while it is free or being taken,
// paced by the controller's one-item-at-a-time sequence and the output register.
// Reset: rst_ni clears the controller state and the output valid; payload holds no reset.
`default_nettype none

module ipv4_datagram_fragmenter_unit #(
  parameter int MAX_FRAGMENTS = 64
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire ipv4fr_pkg::in_item_t  in_item_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output ipv4fr_pkg::out_item_t      out_item_o
);
  import ipv4fr_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // Controller: take one item in idle, compute step and fragment limit, then
  // emit results into the output register whenever it is free or being taken.
  ipv4fr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Datapath: the fragment count limit is checked as payload > MAX * step,
  // and fragments walk the payload by repeated subtraction, so no divider.
  ipv4fr_datapath #(
    .MaxFragments (MAX_FRAGMENTS)
  ) u_datapath (
    .clk_i      (clk_i),
    .in_item_i  (in_item_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_item_o (out_item_o)
  );

  // Busy right after an item is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken while previous item still in work");

  // While a non-final result waits, the item is still in work.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_item_o.last) |-> in_stall_o)
    else $error("input open before all fragments emitted");

  // Error results always close their item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_item_o.kind == KIND_CANNOT ||
                     out_item_o.kind == KIND_FRAG_NEEDED)) |-> out_item_o.last)
    else $error("error result not marked last");

endmodule

`default_nettype wire

// ----- sim/ipv4_datagram_fragmenter_unit_tb.sv -----
// Self-checking testbench for the IPv4 datagram fragmenter: directed and random datagrams.
`default_nettype none

module ipv4_datagram_fragmenter_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ipv4fr_pkg::*;

  localparam int          FRAG_LIMIT   = 64;
  localparam int          RANDOM_ITEMS = 480;
  // Quiet tail: the last stretch of the random part runs without any idling.
  localparam int          QUIET_ITEMS  = 60;
  // Budget for the worst case: about 500 items of up to 64 fragments each, with receiver stalls.
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int          DRAIN_CYCLES = 20;

  // Scoreboard: predict the fragments of each accepted datagram, then match them in order.
  class frag_scoreboard;
    out_item_t expected_frags[$];
    int        mismatches;

    function new();
      mismatches = 0;
    endfunction

    // Work out every result that one datagram causes and queue them in emit order.
    function void note_datagram(in_item_t d);
      int unsigned total, hdr, mtu, step, payload, count, i;
      bit          at_end;
      out_item_t   r;
      total = 32'(d.dgram_length);
      hdr   = 32'(d.header_length);
      mtu   = 32'(d.link_mtu);
      r.kind         = KIND_SEND;
      r.frag_length  = d.dgram_length;
      r.frag_offset  = '0;
      r.more_flag    = d.more_fragments_in;
      r.out_iface    = d.iface_id;
      r.out_next_hop = d.next_hop;
      r.last         = 1'b1;
      if (total <= mtu) begin
        r.kind = (d.hop_limit == 8'd0) ? KIND_TIME_EXCEED : KIND_SEND;
        expected_frags.push_back(r);
        return;
      end
      // No room for payload beats don't-fragment.
      if (mtu <= hdr) begin
        r.kind = KIND_CANNOT;
        expected_frags.push_back(r);
        return;
      end
      if (d.dont_fragment) begin
        r.kind = KIND_FRAG_NEEDED;
        expected_frags.push_back(r);
        return;
      end
      step    = mtu - hdr;
      payload = total - hdr;
      count   = (payload + step - 1) / step;
      if (count > FRAG_LIMIT) begin
        r.kind = KIND_CANNOT;
        expected_frags.push_back(r);
        return;
      end
      for (i = 0; i < count; i++) begin
        at_end        = (i + 1 == count);
        r.kind        = (d.hop_limit == 8'd0) ? KIND_TIME_EXCEED : KIND_FRAG;
        r.frag_length = at_end ? 16'(total - (count - 1) * step) : d.link_mtu;
        r.frag_offset = 16'(i * step);
        r.more_flag   = at_end ? d.more_fragments_in : 1'b1;
        r.last        = at_end;
        expected_frags.push_back(r);
      end
    endfunction

    function void report(string what, out_item_t want, out_item_t got);
      mismatches++;
      if (mismatches <= 10)
        $display({"[%0t] %s: expected kind=%0d len=%0d off=%0d mf=%0b if=%0d hop=%h ",
                  "last=%0b, got kind=%0d len=%0d off=%0d mf=%0b if=%0d hop=%h last=%0b"},
                 $time, what, want.kind, want.frag_length, want.frag_offset, want.more_flag,
                 want.out_iface, want.out_next_hop, want.last, got.kind, got.frag_length,
                 got.frag_offset, got.more_flag, got.out_iface, got.out_next_hop, got.last);
    endfunction

    // Compare one accepted result against the oldest prediction, field by field.
    function void check_fragment(out_item_t got);
      out_item_t want;
      if (expected_frags.size() == 0) begin
        report("result with nothing pending", '0, got);
        return;
      end
      want = expected_frags.pop_front();
      if (got.kind !== want.kind || got.frag_length !== want.frag_length ||
          got.frag_offset !== want.frag_offset || got.more_flag !== want.more_flag ||
          got.out_iface !== want.out_iface || got.out_next_hop !== want.out_next_hop ||
          got.last !== want.last)
        report("result mismatch", want, got);
    endfunction
  endclass

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  in_item_t    in_item_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_item_t   out_item_o;

  frag_scoreboard sb = new();

  // Idling controls, changed by the stimulus as the run moves through its phases.
  bit          src_idling  = 1'b1;
  bit          sink_idling = 1'b1;
  int          sink_burst  = 0;
  int unsigned cycle_count = 0;

  ipv4_datagram_fragmenter_unit #(
    .MAX_FRAGMENTS(FRAG_LIMIT)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  // 2 ns clock.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Sample both handshakes at the edge: note accepted datagrams, check accepted results.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_datagram(in_item_i);
      if (out_valid_o && !out_stall_i) sb.check_fragment(out_item_o);
    end
  end

  // Receiver back-pressure: stall in bursts of random length while idling is enabled.
  always @(posedge clk_i) begin
    if (sink_burst != 0) begin
      out_stall_i <= 1'b1;
      sink_burst  <= sink_burst - 1;
    end else if (sink_idling && $urandom_range(0, 3) == 0) begin
      out_stall_i <= 1'b1;
      sink_burst  <= $urandom_range(0, 5);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Watchdog: end the run if the cycle budget runs out.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  // Present one datagram and hold it until the block takes it. Leave valid high so a
  // following item can go out back to back.
  task automatic drive_item(in_item_t d);
    in_valid_i <= 1'b1;
    in_item_i  <= d;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Insert a random gap on the input side when source idling is on.
  task automatic idle_input();
    if (src_idling && $urandom_range(0, 2) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  // Drop valid and hold off until every predicted result has come out. Step one edge
  // first so the item taken at this edge is already in the scoreboard.
  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_frags.size() != 0) @(posedge clk_i);
  endtask

  function automatic in_item_t datagram(int unsigned total, int unsigned hdr,
                                        int unsigned df, int unsigned mf,
                                        int unsigned ttl, int unsigned mtu,
                                        int unsigned iface, int unsigned hop);
    in_item_t d;
    d.dgram_length      = 16'(total);
    d.header_length     = 6'(hdr);
    d.dont_fragment     = 1'(df);
    d.more_fragments_in = 1'(mf);
    d.hop_limit         = 8'(ttl);
    d.link_mtu          = 16'(mtu);
    d.iface_id          = 8'(iface);
    d.next_hop          = hop;
    return d;
  endfunction

  // Random datagram. Most are well-formed fragmentation jobs (total > MTU > header,
  // don't-fragment clear); the rest fit, hit an error path, or are pure noise.
  function automatic in_item_t make_datagram();
    in_item_t    d;
    int unsigned hdr, step, maxc, count, payload, mtu, pick;
    hdr  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(20, 60);
    pick = $urandom_range(0, 99);
    d = datagram(0, hdr, 0, $urandom_range(0, 1),
                 ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(0, 255),
                 0, $urandom_range(0, 255), $urandom);
    if (pick < 8) begin
      // Noise: every field random.
      d.dgram_length  = 16'($urandom);
      d.header_length = 6'($urandom);
      d.dont_fragment = 1'($urandom_range(0, 1));
      d.link_mtu      = 16'($urandom);
    end else if (pick < 18) begin
      // Fits the MTU.
      d.dgram_length  = 16'($urandom);
      d.link_mtu      = 16'($urandom_range(d.dgram_length, 65535));
      d.dont_fragment = 1'($urandom_range(0, 1));
    end else if (pick < 24) begin
      // Too big with don't-fragment set.
      mtu = $urandom_range(hdr + 1, 65534);
      d.link_mtu      = 16'(mtu);
      d.dgram_length  = 16'($urandom_range(mtu + 1, 65535));
      d.dont_fragment = 1'b1;
    end else if (pick < 28) begin
      // MTU leaves no room for payload.
      mtu = $urandom_range(0, hdr);
      d.link_mtu      = 16'(mtu);
      d.dgram_length  = 16'($urandom_range(mtu + 1, 65535));
      d.dont_fragment = 1'($urandom_range(0, 1));
    end else begin
      // Fragmentation: pick a per-fragment payload step and a count, mostly small,
      // now and then up to just past the fragment limit.
      step  = ($urandom_range(0, 4) == 0) ? $urandom_range(1, (65535 - hdr) / 2)
                                          : $urandom_range(1, 1500);
      maxc  = (65535 - hdr) / step;
      count = ($urandom_range(0, 4) == 0) ? $urandom_range(2, (maxc < 66) ? maxc : 66)
                                          : $urandom_range(2, (maxc < 8) ? maxc : 8);
      payload = (count - 1) * step + $urandom_range(1, step);
      d.link_mtu     = 16'(hdr + step);
      d.dgram_length = 16'(hdr + payload);
    end
    return d;
  endfunction

  initial begin
    in_item_t directed_q[$];
    int       k;
    int       failures;

    // Hold reset low from the start, then release it at an edge.
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed datagrams: field extremes, every result kind, each corner of the split.
    directed_q.push_back(datagram(1500, 20, 0, 0, 64, 1500, 1, 32'h0A000001));   // exact fit
    directed_q.push_back(datagram(1000, 20, 0, 1, 0, 1500, 2, 32'hC0A80101));    // fit, expired
    directed_q.push_back(datagram(0, 0, 0, 0, 255, 0, 0, 32'h0));                 // all zero but TTL
    directed_q.push_back(datagram(65535, 63, 1, 1, 255, 65535, 255, 32'hFFFFFFFF));
    directed_q.push_back(datagram(100, 20, 0, 0, 9, 20, 3, 32'h01020304));       // MTU = header
    directed_q.push_back(datagram(100, 20, 1, 1, 9, 10, 4, 32'h05060708));       // MTU < hdr, DF
    directed_q.push_back(datagram(1, 0, 0, 0, 1, 0, 5, 32'h11111111));           // MTU zero
    directed_q.push_back(datagram(1500, 20, 1, 0, 30, 576, 6, 32'h22222222));    // DF set
    directed_q.push_back(datagram(1500, 20, 0, 0, 30, 576, 7, 32'h33333333));    // 3 fragments
    directed_q.push_back(datagram(1500, 20, 0, 1, 30, 576, 8, 32'h44444444));    // keep MF
    directed_q.push_back(datagram(1500, 20, 0, 1, 0, 576, 9, 32'h55555555));     // expired split
    directed_q.push_back(datagram(532, 20, 0, 0, 7, 28, 10, 32'h66666666));      // exactly 64
    directed_q.push_back(datagram(540, 20, 0, 1, 7, 28, 11, 32'h77777777));      // 65 -> cannot
    directed_q.push_back(datagram(65535, 60, 0, 0, 128, 65534, 12, 32'h88888888));
    directed_q.push_back(datagram(65535, 60, 0, 1, 128, 1100, 13, 32'h99999999)); // 63 frags
    directed_q.push_back(datagram(65535, 60, 0, 0, 128, 1060, 14, 32'hAAAAAAAA)); // 66 frags
    directed_q.push_back(datagram(200, 0, 0, 0, 3, 100, 15, 32'hBBBBBBBB));      // zero header
    directed_q.push_back(datagram(100, 63, 0, 1, 3, 90, 16, 32'hCCCCCCCC));      // max header
    directed_q.push_back(datagram(1000, 63, 0, 0, 3, 64, 17, 32'hDDDDDDDD));     // step 1
    directed_q.push_back(datagram(61, 60, 0, 0, 200, 61, 240, 32'hEEEEEEEE));    // tiny fit
    directed_q.push_back(datagram(62, 60, 0, 0, 200, 61, 128, 32'h7FFFFFFF));    // 2 frags
    foreach (directed_q[i]) begin
      drive_item(directed_q[i]);
      idle_input();
    end

    // Pause the source until every directed result is in.
    wait_for_drain();

    for (k = 0; k < RANDOM_ITEMS; k++) begin
      // Rotate the idling mix every 50 items; run the tail without any idling.
      if (k >= RANDOM_ITEMS - QUIET_ITEMS) begin
        src_idling  = 1'b0;
        sink_idling = 1'b0;
      end else begin
        src_idling  = ((k / 50) % 4) inside {0, 1};
        sink_idling = ((k / 50) % 4) inside {0, 2};
      end
      if (k == RANDOM_ITEMS / 2) wait_for_drain();
      drive_item(make_datagram());
      idle_input();
    end

    // Let the last results out, then wait DRAIN_CYCLES more for anything stray.
    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    failures = sb.mismatches + sb.expected_frags.size();
    if (failures == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

`default_nettype wire
